/* src/jacobi_laplace_stencil_stream_unit_macros.svh */
// Assertion macros for the Jacobi stencil stream unit.
// Used by the top level only; no other dependencies.
`ifndef JACOBI_LAPLACE_STENCIL_STREAM_UNIT_MACROS_SVH
`define JACOBI_LAPLACE_STENCIL_STREAM_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define JLS_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("jls: same-cycle check failed");
// next-cycle implication
`define JLS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("jls: next-cycle check failed");
`else
`define JLS_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define JLS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* src/jls_pkg.sv */
// Shared types and constants for the Jacobi stencil stream unit.
// No dependencies.
`timescale 1ns / 1ps
package jls_pkg;

   localparam int SAMPLE_W = 24;
   localparam int PEAK_W   = 23;
   localparam int CNT_W    = 12;
   localparam int SIZE_W   = 13;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam logic [PEAK_W-1:0] PEAK_MAX   = 23'h7FFFFF;
   localparam logic [SIZE_W-1:0] SIZE_MIN   = 13'd3;
   localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;
   localparam logic [SIZE_W-1:0] ROW_LIMIT  = 13'd4096;

   // register index, taken from paddr[2]
   localparam logic REG_GRID_COLS = 1'b0;
   localparam logic REG_GRID_ROWS = 1'b1;

   typedef struct packed {
      logic [SIZE_W-1:0] cols;
      logic [SIZE_W-1:0] rows;
   } geom_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      logic signed [SAMPLE_W-1:0] up;
      logic signed [SAMPLE_W-1:0] centre;
      logic                       produce;
      logic                       last;
      logic                       clear;
   } window_type;

   typedef struct packed {
      logic s1_valid;
      logic s1_produce;
   } core_status_type;

endpackage

/* src/jls_csr.sv */
// Configuration registers (APB-style) with size clamping.
// Depends on jls_pkg.
`timescale 1ns / 1ps
module jls_csr #(
   parameter int MAX_COLS = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [jls_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [jls_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [jls_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready,
   output jls_pkg::geom_type             geom
);
   import jls_pkg::*;

   logic [SIZE_W-1:0] cols_ff, cols_in;
   logic [SIZE_W-1:0] rows_ff, rows_in;
   logic              wr_en;
   logic              reg_sel;

   assign wr_en   = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel = csr_paddr[2];

   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_GRID_COLS: cols_in = csr_pwdata[SIZE_W-1:0];
            REG_GRID_ROWS: rows_in = csr_pwdata[SIZE_W-1:0];
            default:       cols_in = cols_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= SIZE_RESET;
         rows_ff <= SIZE_RESET;
      end else begin
         cols_ff <= cols_in;
         rows_ff <= rows_in;
      end
   end

   always_comb begin
      case (reg_sel)
         REG_GRID_COLS: csr_prdata = CSR_DW'(cols_ff);
         REG_GRID_ROWS: csr_prdata = CSR_DW'(rows_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   // clamp to the supported geometry
   always_comb begin
      if (cols_ff < SIZE_MIN)
         geom.cols = SIZE_MIN;
      else if (32'(cols_ff) > MAX_COLS)
         geom.cols = SIZE_W'(MAX_COLS);
      else
         geom.cols = cols_ff;

      if (rows_ff < SIZE_MIN)
         geom.rows = SIZE_MIN;
      else if (rows_ff > ROW_LIMIT)
         geom.rows = ROW_LIMIT;
      else
         geom.rows = rows_ff;
   end

endmodule

/* src/jls_line_buffer.sv */
// Raster position counters and the two line stores; presents the 4-point window.
// Depends on jls_pkg.
`timescale 1ns / 1ps
module jls_line_buffer #(
   parameter int MAX_COLS = 4096
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  accept,
   input  logic signed [jls_pkg::SAMPLE_W-1:0]   sample,
   input  jls_pkg::geom_type                     geom,
   output jls_pkg::window_type                   window
);
   import jls_pkg::*;

   localparam int AW = $clog2(MAX_COLS);

   logic [SAMPLE_W-1:0] older_mem [MAX_COLS];
   logic [SAMPLE_W-1:0] newer_mem [MAX_COLS];

   logic [CNT_W-1:0]    col_ff, col_in;
   logic [CNT_W-1:0]    row_ff, row_in;
   logic [SAMPLE_W-1:0] prior_ff, prior_in;
   logic [SAMPLE_W-1:0] newer_c_ff, newer_r_ff, older_c_ff;

   logic [SIZE_W-1:0]   col_inc, row_inc, next_inc;
   logic                col_wrap, row_wrap;
   logic [AW-1:0]       wr_addr, rd_c_addr, rd_r_addr;

   assign col_inc  = {1'b0, col_ff} + SIZE_W'(1);
   assign row_inc  = {1'b0, row_ff} + SIZE_W'(1);
   assign col_wrap = col_inc >= geom.cols;
   assign row_wrap = row_inc >= geom.rows;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_inc[CNT_W-1:0];
         end else begin
            col_in = col_inc[CNT_W-1:0];
         end
      end
   end

   assign prior_in = accept ? newer_c_ff : prior_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         prior_ff <= '0;
      end else begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         prior_ff <= prior_in;
      end
   end

   // read one column ahead so the window is ready when the sample arrives
   assign next_inc  = {1'b0, col_in} + SIZE_W'(1);
   assign wr_addr   = AW'(col_ff);
   assign rd_c_addr = AW'(col_in);
   assign rd_r_addr = (32'(next_inc) == MAX_COLS) ? '0 : AW'(next_inc);

   always_ff @(posedge clock) begin
      if (accept) begin
         older_mem[wr_addr] <= newer_c_ff;
         newer_mem[wr_addr] <= sample;
      end
      newer_c_ff <= newer_mem[rd_c_addr];
      newer_r_ff <= newer_mem[rd_r_addr];
      older_c_ff <= older_mem[rd_c_addr];
   end

   always_comb begin
      window.left    = prior_ff;
      window.right   = newer_r_ff;
      window.up      = older_c_ff;
      window.centre  = newer_c_ff;
      window.produce = (row_ff >= CNT_W'(2)) && ({1'b0, row_ff} < geom.rows)
                    && (col_ff >= CNT_W'(1))
                    && (({1'b0, col_ff} + SIZE_W'(2)) <= geom.cols);
      window.last    = (row_inc == geom.rows)
                    && (({1'b0, col_ff} + SIZE_W'(2)) == geom.cols);
      window.clear   = (row_ff == '0) && (col_ff == '0);
   end

endmodule

/* src/jls_stencil_core.sv */
// Two-stage stencil datapath: neighbour average, then change magnitude,
// running peak and output register. Depends on jls_pkg.
`timescale 1ns / 1ps
module jls_stencil_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [jls_pkg::SAMPLE_W-1:0]   sample,
   input  jls_pkg::window_type                   window,
   output logic                                  accept,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [jls_pkg::SAMPLE_W-1:0]   rsp_new_value,
   output logic [jls_pkg::PEAK_W-1:0]            rsp_max_change,
   output logic                                  rsp_last_point,
   output jls_pkg::core_status_type              status
);
   import jls_pkg::*;

   // stage 1
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_produce_ff, s1_last_ff, s1_clear_ff;
   logic [SAMPLE_W-1:0] s1_avg_ff, s1_centre_ff;
   // stage 2 / output
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_value_ff;
   logic [PEAK_W-1:0]   rsp_peak_ff;
   logic                rsp_last_ff;
   logic [PEAK_W-1:0]   peak_ff, peak_in;

   logic                load_s1, advance;
   logic [SAMPLE_W+1:0] sum;
   logic [SAMPLE_W:0]   diff, mag;
   logic [PEAK_W-1:0]   sat, base_peak, new_peak;

   assign advance   = s1_valid_ff && (!s1_produce_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;
   assign load_s1   = accept && (window.produce || window.clear);

   // floor average of the four neighbours
   assign sum = {{2{window.left[SAMPLE_W-1]}},  window.left}
              + {{2{window.right[SAMPLE_W-1]}}, window.right}
              + {{2{window.up[SAMPLE_W-1]}},    window.up}
              + {{2{sample[SAMPLE_W-1]}},       sample};

   assign s1_valid_in = load_s1 ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_s1) begin
         s1_produce_ff <= window.produce;
         s1_last_ff    <= window.last;
         s1_clear_ff   <= window.clear;
         s1_avg_ff     <= sum[SAMPLE_W+1:2];
         s1_centre_ff  <= window.centre;
      end
   end

   // |new - old|, saturated, folded into the sweep peak
   assign diff = {s1_avg_ff[SAMPLE_W-1], s1_avg_ff}
               - {s1_centre_ff[SAMPLE_W-1], s1_centre_ff};
   assign mag  = diff[SAMPLE_W] ? (~diff + (SAMPLE_W+1)'(1)) : diff;
   assign sat  = (mag > (SAMPLE_W+1)'(PEAK_MAX)) ? PEAK_MAX : mag[PEAK_W-1:0];
   assign base_peak = s1_clear_ff ? '0 : peak_ff;
   assign new_peak  = (sat > base_peak) ? sat : base_peak;

   assign peak_in = advance ? (s1_produce_ff ? new_peak : '0) : peak_ff;
   assign rsp_valid_in = (advance && s1_produce_ff) ? 1'b1
                       : ((rsp_valid_ff && rsp_ready) ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         peak_ff      <= peak_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_produce_ff) begin
         rsp_value_ff <= s1_avg_ff;
         rsp_peak_ff  <= new_peak;
         rsp_last_ff  <= s1_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_new_value  = rsp_value_ff;
   assign rsp_max_change = rsp_peak_ff;
   assign rsp_last_point = rsp_last_ff;

   assign status.s1_valid   = s1_valid_ff;
   assign status.s1_produce = s1_produce_ff;

endmodule

/* src/jacobi_laplace_stencil_stream_unit.sv */
// Top level of the Jacobi four-point stencil stream unit.
// Depends on jls_pkg, jls_csr, jls_line_buffer, jls_stencil_core and the macros header.
`timescale 1ns / 1ps
// One Jacobi relaxation sweep over a raster stream of signed Q1.22 samples.
// Every req_ transaction carries one grid sample, row by row; the unit returns
// one rsp_ transaction per interior point (boundary rows and columns give
// nothing), holding the floor average of the four neighbours, the running
// peak of |new - old| for the sweep (saturated at 23 bits) and a flag on the
// last interior point. Interior point (r-1, c) is returned after sample (r, c)
// has been taken. Throughput is one sample per clock while rsp_ is not held off;
// each result is registered in the average stage and then in the output register.
// The line stores are read one column ahead, so the neighbour window is ready
// when the sample arrives. Back-pressure on rsp_ stalls the pipeline and drops
// req_ready. There is no clearing pass after reset: the stores' contents are
// only used where they have been written in the same sweep.
// grid_cols (byte address 0) and grid_rows (byte address 4) are clamped to
// 3..MAX_COLS and 3..4096; write them only between transactions.
module jacobi_laplace_stencil_stream_unit #(
   parameter int MAX_COLS = 4096
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // sample stream
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [jls_pkg::SAMPLE_W-1:0]   req_sample,
   // result stream
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [jls_pkg::SAMPLE_W-1:0]   rsp_new_value,
   output logic [jls_pkg::PEAK_W-1:0]            rsp_max_change,
   output logic                                  rsp_last_point,
   // configuration port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [jls_pkg::CSR_AW-1:0]            csr_paddr,
   input  logic [jls_pkg::CSR_DW-1:0]            csr_pwdata,
   output logic [jls_pkg::CSR_DW-1:0]            csr_prdata,
   output logic                                  csr_pready
);
   import jls_pkg::*;

   geom_type        geom;
   window_type      window;
   core_status_type status;
   logic            accept;

   // register file and geometry clamp
   jls_csr #(
      .MAX_COLS (MAX_COLS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .geom        (geom)
   );

   // raster counters and two line stores
   jls_line_buffer #(
      .MAX_COLS (MAX_COLS)
   ) u_line_buffer (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .sample (req_sample),
      .geom   (geom),
      .window (window)
   );

   // average, change peak, output register
   jls_stencil_core u_core (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .sample         (req_sample),
      .window         (window),
      .accept         (accept),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_new_value  (rsp_new_value),
      .rsp_max_change (rsp_max_change),
      .rsp_last_point (rsp_last_point),
      .status         (status)
   );

   // empty average stage never blocks the input
`include "jacobi_laplace_stencil_stream_unit_macros.svh"
   `JLS_ASSERT_IMPLIES(a_ready_when_empty, clock, reset, !status.s1_valid, req_ready)
   // a pending point moves into an empty output register
   `JLS_ASSERT_NEXT(a_point_reaches_output, clock, reset, status.s1_valid && status.s1_produce && !rsp_valid, rsp_valid)
   // the sweep-start sample is never an interior point
   `JLS_ASSERT_IMPLIES(a_clear_not_interior, clock, reset, accept && window.clear, !window.produce)

endmodule

/* tb/jls_stencil_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the Jacobi stencil stream unit. It mirrors the sweep in its own line stores
// and checks each rsp_ transaction against the oldest predicted point.
// Depends on jls_pkg; instantiated beside the unit by the testbench top.
module jls_stencil_checker #(
   parameter int MAX_COLS = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic signed [jls_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [jls_pkg::SAMPLE_W-1:0] rsp_new_value,
   input  logic [jls_pkg::PEAK_W-1:0]          rsp_max_change,
   input  logic                                rsp_last_point,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [jls_pkg::CSR_AW-1:0]          csr_paddr,
   input  logic [jls_pkg::CSR_DW-1:0]          csr_pwdata,
   input  logic                                csr_pready,
   output int                                  fail_count,
   output int                                  outstanding,
   output int                                  points_checked
);
   import jls_pkg::*;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] new_value;
      logic [PEAK_W-1:0]          max_change;
      logic                       last_point;
   } point_result_type;

   point_result_type           expected_points[$];
   logic signed [SAMPLE_W-1:0] line_near [MAX_COLS];   // row r-1
   logic signed [SAMPLE_W-1:0] line_far  [MAX_COLS];   // row r-2
   logic signed [SAMPLE_W-1:0] left_prev;              // row r-1, previous column
   logic [SIZE_W-1:0]          cols_reg;
   logic [SIZE_W-1:0]          rows_reg;
   logic [PEAK_W-1:0]          peak_change;
   int                         row_pos;
   int                         col_pos;

   initial begin
      fail_count     = 0;
      outstanding    = 0;
      points_checked = 0;
   end

   function automatic int clamp_size(logic [SIZE_W-1:0] v, int hi);
      if (v < SIZE_MIN) return 3;
      if (v > hi) return hi;
      return int'(v);
   endfunction

   task automatic report_mismatch(string msg);
      if (fail_count < 20) $display("[%0t] stencil check: %s", $time, msg);
      fail_count++;
   endtask

   task automatic take_sample(logic signed [SAMPLE_W-1:0] s);
      int                         cols_eff;
      int                         rows_eff;
      int                         here;
      int                         ahead;
      logic signed [SAMPLE_W+1:0] total;
      logic signed [SAMPLE_W+1:0] quarter;
      logic signed [SAMPLE_W-1:0] centre;
      logic signed [SAMPLE_W-1:0] avg;
      logic signed [SAMPLE_W:0]   delta;
      logic [SAMPLE_W:0]          mag;
      logic [PEAK_W-1:0]          change;
      point_result_type           point;
      cols_eff = clamp_size(cols_reg, MAX_COLS);
      rows_eff = clamp_size(rows_reg, int'(ROW_LIMIT));
      here     = col_pos % MAX_COLS;
      ahead    = (col_pos + 1) % MAX_COLS;
      if (row_pos == 0 && col_pos == 0) peak_change = '0;
      if (row_pos >= 2 && row_pos < rows_eff && col_pos >= 1 && col_pos + 2 <= cols_eff) begin
         centre  = line_near[here];
         total   = left_prev + line_near[ahead] + line_far[here] + s;
         quarter = total >>> 2;
         avg     = quarter[SAMPLE_W-1:0];
         delta   = avg - centre;
         mag     = (delta < 0) ? -delta : delta;
         change  = (mag > PEAK_MAX) ? PEAK_MAX : mag[PEAK_W-1:0];
         if (change > peak_change) peak_change = change;
         point.new_value  = avg;
         point.max_change = peak_change;
         point.last_point = (row_pos + 1 == rows_eff) && (col_pos + 2 == cols_eff);
         expected_points.push_back(point);
      end
      left_prev       = line_near[here];
      line_far[here]  = line_near[here];
      line_near[here] = s;
      if (col_pos + 1 >= cols_eff) begin
         col_pos = 0;
         row_pos = (row_pos + 1 >= rows_eff) ? 0 : row_pos + 1;
      end else begin
         col_pos++;
      end
   endtask

   task automatic check_point();
      point_result_type want;
      if (expected_points.size() == 0) begin
         report_mismatch($sformatf("result with none pending: value %0d change %0d last %0b",
                                   rsp_new_value, rsp_max_change, rsp_last_point));
         return;
      end
      want = expected_points.pop_front();
      if (rsp_new_value !== want.new_value)
         report_mismatch($sformatf("point %0d new_value %0d, want %0d",
                                   points_checked, rsp_new_value, want.new_value));
      if (rsp_max_change !== want.max_change)
         report_mismatch($sformatf("point %0d max_change %0d, want %0d",
                                   points_checked, rsp_max_change, want.max_change));
      if (rsp_last_point !== want.last_point)
         report_mismatch($sformatf("point %0d last_point %0b, want %0b",
                                   points_checked, rsp_last_point, want.last_point));
      points_checked++;
   endtask

   // samples are taken before results so a result returned in the same cycle as its sample would still line up
   always @(posedge clock) begin
      if (reset) begin
         cols_reg    = SIZE_RESET;
         rows_reg    = SIZE_RESET;
         row_pos     = 0;
         col_pos     = 0;
         left_prev   = '0;
         peak_change = '0;
         expected_points.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_GRID_COLS) cols_reg = csr_pwdata[SIZE_W-1:0];
            else rows_reg = csr_pwdata[SIZE_W-1:0];
         end
         if (req_valid && req_ready) take_sample(req_sample);
         if (rsp_valid && rsp_ready) check_point();
      end
      outstanding = expected_points.size();
   end

endmodule

/* tb/jacobi_laplace_stencil_stream_unit_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the Jacobi stencil stream unit: clock, reset, sample stimulus,
// register writes, result back-pressure and the verdict. Depends on jls_pkg and jls_stencil_checker.
module jacobi_laplace_stencil_stream_unit_tb;
   import jls_pkg::*;

   localparam int MAX_COLS      = 4096;
   localparam int RANDOM_ITEMS  = 1000;
   localparam int LONG_HOLD     = 300;   // receiver hold-off, long enough to back up the pipe
   localparam int SETTLE_CYCLES = 8;     // idle clocks after a drain, for the pipe to settle
   localparam int LARGEST_GAP   = 8;

   // sample flavours for a sweep
   localparam int STYLE_FULL  = 0;   // whole Q1.22 range
   localparam int STYLE_SMALL = 1;   // near zero, keeps the change peak low
   localparam int STYLE_EDGE  = 2;   // rails, zero and minus one

   localparam logic [CSR_AW-1:0] ADDR_GRID_COLS = {REG_GRID_COLS, 2'b00};
   localparam logic [CSR_AW-1:0] ADDR_GRID_ROWS = {REG_GRID_ROWS, 2'b00};

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;

   logic                       clock       = 1'b0;
   logic                       reset       = 1'b1;
   logic                       req_valid   = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample  = '0;
   logic                       rsp_valid;
   logic                       rsp_ready   = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_new_value;
   logic [PEAK_W-1:0]          rsp_max_change;
   logic                       rsp_last_point;
   logic                       csr_psel    = 1'b0;
   logic                       csr_penable = 1'b0;
   logic                       csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0]          csr_paddr   = '0;
   logic [CSR_DW-1:0]          csr_pwdata  = '0;
   logic [CSR_DW-1:0]          csr_prdata;
   logic                       csr_pready;

   int  fail_count;
   int  outstanding;
   int  points_checked;

   // stimulus bookkeeping
   int  items_sent    = 0;
   int  sweeps_run    = 0;
   int  burst_left    = 0;
   int  cur_cols      = 4096;
   int  cur_rows      = 4096;
   bit  sender_eager  = 1'b0;
   bit  long_hold_req = 1'b0;   // raised by the stimulus, cleared by the receiver
   int  holds_done    = 0;

   always #5 clock = ~clock;

   jacobi_laplace_stencil_stream_unit #(
      .MAX_COLS (MAX_COLS)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_new_value  (rsp_new_value),
      .rsp_max_change (rsp_max_change),
      .rsp_last_point (rsp_last_point),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   // Watches all three ports, predicts each interior point and counts mismatches.
   jls_stencil_checker #(
      .MAX_COLS (MAX_COLS)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_new_value  (rsp_new_value),
      .rsp_max_change (rsp_max_change),
      .rsp_last_point (rsp_last_point),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_pready     (csr_pready),
      .fail_count     (fail_count),
      .outstanding    (outstanding),
      .points_checked (points_checked)
   );

   // Sizes as the unit uses them: register values below 3 or above 4096 are clamped.
   function automatic int clamp_size(logic [SIZE_W-1:0] v);
      if (v < SIZE_MIN) return 3;
      if (v > 13'd4096) return 4096;
      return int'(v);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] pick_sample(int style);
      int near_zero;
      case (style)
         STYLE_SMALL: begin
            near_zero = $urandom_range(0, 16);
            near_zero = near_zero - 8;
            return near_zero[SAMPLE_W-1:0];
         end
         STYLE_EDGE: begin
            case ($urandom_range(0, 3))
               0:       return SAMPLE_MAX;
               1:       return SAMPLE_MIN;
               2:       return '0;
               default: return '1;
            endcase
         end
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // APB write: setup cycle, access cycle, then a return to idle so that
   // back-to-back writes never drive psel twice in one step.
   task automatic csr_write(logic [CSR_AW-1:0] addr, logic [SIZE_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= {{(CSR_DW-SIZE_W){1'b0}}, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Sender stops, waits for every predicted point to come back, then lets
   // the pipe settle before anything else happens.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Geometry changes only with the unit idle and at a sweep boundary, so the
   // line stores are never read where this sweep has not written them.
   task automatic set_geometry(logic [SIZE_W-1:0] cols_val, logic [SIZE_W-1:0] rows_val);
      drain_results();
      csr_write(ADDR_GRID_COLS, cols_val);
      csr_write(ADDR_GRID_ROWS, rows_val);
      cur_cols = clamp_size(cols_val);
      cur_rows = clamp_size(rows_val);
   endtask

   // One req_ transaction. Bursts of random length with random gaps between
   // them, unless the sweep runs eager. valid stays up across a burst.
   task automatic offer_sample(logic signed [SAMPLE_W-1:0] value);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, LARGEST_GAP);
         if (!sender_eager && gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid  <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (!req_ready);
      items_sent++;
   endtask

   // Full raster sweep at the current geometry. Now and then the sender
   // pauses mid-sweep until every outstanding point has been returned.
   task automatic run_sweep(int style);
      sender_eager = ($urandom_range(0, 3) == 0);
      for (int r = 0; r < cur_rows; r++) begin
         for (int c = 0; c < cur_cols; c++) begin
            offer_sample(pick_sample(style));
            if ($urandom_range(0, 299) == 0) begin
               req_valid <= 1'b0;
               do @(posedge clock); while (outstanding != 0);
            end
         end
      end
      sweeps_run++;
   endtask

   // 3x3 sweep with one interior point: centre value and a common rim value.
   task automatic send_cross(logic signed [SAMPLE_W-1:0] centre,
                             logic signed [SAMPLE_W-1:0] rim);
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            offer_sample((r == 1 && c == 1) ? centre : rim);
      sweeps_run++;
   endtask

   // Result side: stretches of always-ready, coin-toss, sparse and mostly-ready
   // back-pressure, plus the occasional long hold-off on request.
   initial begin : result_sink
      int pattern;
      int span;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            holds_done++;
         end else begin
            pattern = $urandom_range(0, 3);
            span    = $urandom_range(4, 64);
            repeat (span) begin
               case (pattern)
                  0:       rsp_ready <= 1'b1;
                  1:       rsp_ready <= 1'($urandom_range(0, 1));
                  2:       rsp_ready <= ($urandom_range(0, 3) == 0);
                  default: rsp_ready <= ($urandom_range(0, 7) != 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   // Watchdog. Slowest legal run: ~1.6k samples, each behind the longest
   // sender gap and a sparse receiver, plus drains and the long holds;
   // the limit set here lies far beyond that.
   initial begin : watchdog
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      int random_start;
      int next_hold_at;
      logic [SIZE_W-1:0] cols_val;
      logic [SIZE_W-1:0] rows_val;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: out-of-range sizes clamp to a 3x3 grid with a single
      // interior point, which is also the last point of its sweep.
      // Rim at +max around a -max centre: largest average, change saturates.
      set_geometry(13'd0, 13'd1);
      send_cross(SAMPLE_MIN, SAMPLE_MAX);
      // All zero: peak must clear at the sweep start and stay at zero.
      send_cross('0, '0);
      // Rim at -max around a +max centre: most negative average, saturates.
      set_geometry(13'd2, 13'd2);
      send_cross(SAMPLE_MAX, SAMPLE_MIN);

      // Random sweeps, small grids. Geometry usually changes between sweeps;
      // otherwise sweeps run back to back with the pipe still busy.
      random_start = items_sent;
      next_hold_at = 400;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         if ($urandom_range(0, 2) != 0) begin
            cols_val = ($urandom_range(0, 9) == 0) ? SIZE_W'($urandom_range(0, 2))
                                                   : SIZE_W'($urandom_range(3, 24));
            rows_val = ($urandom_range(0, 9) == 0) ? SIZE_W'($urandom_range(0, 2))
                                                   : SIZE_W'($urandom_range(3, 10));
            set_geometry(cols_val, rows_val);
         end
         // receiver goes quiet while samples keep coming: the unit must fill and stall req_
         if (items_sent - random_start >= next_hold_at) begin
            long_hold_req = 1'b1;
            next_hold_at += 400;
         end
         case ($urandom_range(0, 9))
            0, 1:    run_sweep(STYLE_SMALL);
            2, 3:    run_sweep(STYLE_EDGE);
            default: run_sweep(STYLE_FULL);
         endcase
      end

      // Wide rows: a hundred columns over three rows, one interior row.
      set_geometry(13'd100, 13'd3);
      run_sweep(STYLE_FULL);

      drain_results();

      $display("Ran %0d sweeps, %0d samples in, %0d interior points checked.",
               sweeps_run, items_sent, points_checked);
      $display("Grids from 3x3 up to 100 wide and 10 tall, clamped sizes, %0d long hold-offs.",
               holds_done);
      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule
